/* hw/rtl/sbusfd_pkg.sv */
// ----------------------------------------------------------------------------
// S.BUS frame decoder package
// Shared constants and the structs that pass between the frame tracker and
// the channel unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package sbusfd_pkg;

   localparam logic [7:0] SbusHeader = 8'h0F;

   localparam int FrameLen      = 25;   // header, 22 data bytes, flags, end byte
   localparam int PosW          = 5;    // holds byte positions 0 to 24
   localparam int ChanW         = 11;   // width of one channel value
   localparam int ChanIdxW      = 4;    // sixteen channels
   localparam int FirstChanByte = 1;
   localparam int LastChanByte  = 22;
   localparam int AddrW         = PosW + 1;  // bank bit on top of the position
   localparam int AccW          = ChanW + 7; // leftover bits plus one new byte
   localparam int CntW          = 5;         // bit count, 0 to AccW

   localparam logic [PosW-1:0] FooterPos = PosW'(FrameLen - 1);

   // One write into the frame store.
   typedef struct packed {
      logic             en;
      logic [AddrW-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

   // Launch of the unpacker on a completed frame held in one bank.
   typedef struct packed {
      logic go;
      logic bank;
   } unpack_start_type;

endpackage

`default_nettype wire

/* hw/rtl/sbusfd_unpacker.sv */
// ----------------------------------------------------------------------------
// S.BUS channel unpacker
// Holds the two-bank frame store and streams the sixteen 11-bit channels of a
// finished frame out of it, one byte read per cycle while the bit accumulator has room.
// ----------------------------------------------------------------------------
`default_nettype none

module sbusfd_unpacker (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire  sbusfd_pkg::store_wr_type       store_wr,
   input  wire  sbusfd_pkg::unpack_start_type   start,
   output logic                                 busy,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [sbusfd_pkg::ChanIdxW-1:0]      rsp_index,
   output logic [sbusfd_pkg::ChanW-1:0]         rsp_value,
   output logic                                 rsp_last
);
   import sbusfd_pkg::*;

   localparam int StoreDepth = 2 ** AddrW;
   localparam logic [CntW-1:0] RefillLimit = CntW'(AccW - 8);

   logic [7:0] store_mem [StoreDepth];

   logic                busy_ff, busy_in;
   logic                rbank_ff, rbank_in;
   logic [PosW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [7:0]          rd_data_ff;
   logic [AccW-1:0]     acc_ff, acc_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic [ChanIdxW-1:0] chan_ff, chan_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ChanIdxW-1:0] rsp_index_ff;
   logic [ChanW-1:0]    rsp_value_ff;
   logic                rsp_last_ff;

   logic                pop;
   logic                last_chan;
   logic                rd_en;
   logic [AccW-1:0]     acc_sh;
   logic [CntW-1:0]     cnt_sh;
   logic [CntW-1:0]     cnt_after;

   // Frame store: one write port from the tracker, one read port here.
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[{rbank_ff, rd_ptr_ff}];
      end
   end

   always_comb begin
      last_chan = (chan_ff == {ChanIdxW{1'b1}});
      pop       = busy_ff && (cnt_ff >= CntW'(ChanW)) && (!rsp_valid_ff || rsp_ready);
      acc_sh    = pop ? (acc_ff >> ChanW) : acc_ff;
      cnt_sh    = pop ? (cnt_ff - CntW'(ChanW)) : cnt_ff;
      cnt_after = cnt_sh + (rd_pend_ff ? CntW'(8) : CntW'(0));
      // A read is only issued when the byte it returns is sure to fit.
      rd_en     = busy_ff && (rd_ptr_ff <= PosW'(LastChanByte)) && (cnt_after <= RefillLimit);

      busy_in    = busy_ff;
      rbank_in   = rbank_ff;
      rd_ptr_in  = rd_ptr_ff + PosW'(rd_en);
      rd_pend_in = rd_en;
      acc_in     = acc_sh | (rd_pend_ff ? (AccW'(rd_data_ff) << cnt_sh) : '0);
      cnt_in     = cnt_after;
      chan_in    = pop ? (chan_ff + 1'b1) : chan_ff;

      if (pop && last_chan) begin
         busy_in = 1'b0;
      end
      if (start.go) begin
         busy_in    = 1'b1;
         rbank_in   = start.bank;
         rd_ptr_in  = PosW'(FirstChanByte);
         rd_pend_in = 1'b0;
         acc_in     = '0;
         cnt_in     = '0;
         chan_in    = '0;
      end

      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rbank_ff  <= rbank_in;
      rd_ptr_ff <= rd_ptr_in;
      acc_ff    <= acc_in;
      cnt_ff    <= cnt_in;
      chan_ff   <= chan_in;
      if (pop) begin
         rsp_index_ff <= chan_ff;
         rsp_value_ff <= acc_ff[ChanW-1:0];
         rsp_last_ff  <= last_chan;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// S.BUS frame decoder
// Collects 25-byte S.BUS frames from a byte stream and emits the sixteen
// 11-bit channel values of every frame whose end byte matches the footer.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries received serial bytes, one per request. While no
// frame is open, every byte other than the 0x0F header is dropped. From the
// header on, 25 bytes make a frame; a header byte inside a frame is data.
// When the 25th byte equals the footer register, the rsp_ channel delivers
// sixteen requests, channel 0 to 15, with tlast on channel 15. A wrong end
// byte drops the frame silently.
// The csr_ channel writes the footer register (reset value 0x00, the standard
// S.BUS end byte); it is always ready and should be written while idle.
// Bytes are taken one per cycle except while the end byte is held off. The
// frame store has two banks, so a new frame is received while the previous
// one is unpacked. The unpacker reads a store byte only when its accumulator
// has room for it. If the unpacker is still busy with the previous frame when
// the next end byte arrives, that byte is held off (req_tready low) until the
// unpacker is free.
// A stalled receiver holds the result register; unpacking pauses behind it.
// Reset empties the result register and returns to waiting for a header; the
// frame store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder (
   input  wire        clock,
   input  wire        reset,
   // Received bytes. tdata: [7:0] rx_byte.
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,
   // Channel results. tdata: [3:0] channel_index, [14:4] channel_value,
   // [15] zero. tlast: last_channel.
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic       rsp_tlast,
   // Footer register write. data: [7:0] footer_value.
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [7:0] csr_data
);
   import sbusfd_pkg::*;

   logic [7:0]      footer_ff;
   logic [PosW-1:0] pos_ff, pos_in;
   logic            wbank_ff, wbank_in;

   logic             req_accept;
   logic             at_footer;
   logic             unpack_busy;
   store_wr_type     store_wr;
   unpack_start_type start;
   logic [ChanIdxW-1:0] chan_index;
   logic [ChanW-1:0]    chan_value;

   // The end byte is held off only while the other bank is still unpacked.
   assign at_footer  = (pos_ff == FooterPos);
   assign req_tready = !(at_footer && unpack_busy);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      pos_in         = pos_ff;
      wbank_in       = wbank_ff;
      store_wr.en    = 1'b0;
      store_wr.addr  = {wbank_ff, pos_ff};
      store_wr.data  = req_tdata;
      start.go       = 1'b0;
      start.bank     = wbank_ff;

      if (req_accept) begin
         if (at_footer) begin
            // End byte: it is compared, not stored.
            pos_in = '0;
            if (req_tdata == footer_ff) begin
               start.go = 1'b1;
               wbank_in = !wbank_ff;
            end
         end else if ((pos_ff != '0) || (req_tdata == SbusHeader)) begin
            store_wr.en = 1'b1;
            pos_in      = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         footer_ff <= '0;
         pos_ff    <= '0;
         wbank_ff  <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         wbank_ff <= wbank_in;
         if (csr_valid && csr_ready) begin
            footer_ff <= csr_data;
         end
      end
   end

   sbusfd_unpacker u_unpacker (
      .clock     (clock),
      .reset     (reset),
      .store_wr  (store_wr),
      .start     (start),
      .busy      (unpack_busy),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_index (chan_index),
      .rsp_value (chan_value),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, chan_value, chan_index};

endmodule

`default_nettype wire

/* hw/rtl/sbusfd_checker.sv */
// ----------------------------------------------------------------------------
// S.BUS frame decoder checker
// Port-level assertions for the decoder, attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module sbusfd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [15:0] rsp_tdata,
   input wire        rsp_tlast,
   input wire        csr_ready
);

   // A stalled result keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // tlast marks channel 15 and only channel 15.
   a_last_is_ch15: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[3:0] == 4'hF)))
      else $error("tlast does not match channel 15");

   // The pad bit above the channel value stays clear.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[15] == 1'b0))
      else $error("result pad bit set");

   // In the cycle after reset is seen high, nothing is pending and bytes are taken.
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready && csr_ready)
      else $error("decoder not idle after reset");

endmodule

bind sbus_frame_decoder sbusfd_checker u_sbusfd_checker (.*);

`default_nettype wire

/* sim/tb_sbus_frame_decoder.sv */
// ----------------------------------------------------------------------------
// S.BUS frame decoder testbench
// Feeds byte streams made of good frames, frames with a bad end byte and
// line noise, under several footer settings. A local decoder model predicts
// every channel request, and the monitor checks each one in order.
// ----------------------------------------------------------------------------

module tb_sbus_frame_decoder;
   import sbusfd_pkg::*;

   localparam int ClockHigh    = 6;
   localparam int ClockLow     = 6;
   localparam int ResetCycles  = 5;
   localparam int SettleCycles = 48;    // well past the unpacker's drain time
   localparam int QuietLimit   = 1000;  // cycles with no handshake at all
   localparam int MaxReports   = 20;
   localparam int PhaseBytes   = 64;
   localparam int NumChannels  = 16;
   localparam int PayloadBytes = LastChanByte - FirstChanByte + 1;

   // How the channel values of a generated frame are filled.
   localparam int FillZero  = 0;
   localparam int FillOnes  = 1;
   localparam int FillMixed = 2;

   typedef struct packed {
      logic [ChanIdxW-1:0] index;
      logic [ChanW-1:0]    value;
      logic                last;
   } channel_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_data   = 8'h00;

   // Decoder model state.
   logic [7:0]      footer_setting = 8'h00;
   logic [PosW-1:0] frame_pos = '0;
   logic [7:0]      frame_bytes [FrameLen-1];

   channel_type channel_queue [$];
   logic [7:0]  byte_queue [$];
   channel_type want;

   int bytes_queued, bytes_taken, send_gap, hold_left, quiet_cycles;
   int frames_decoded, frames_dropped, channels_checked, footer_writes, errors;
   bit calm = 1'b0;

   sbus_frame_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #ClockLow clock = 1'b1;
      #ClockHigh clock = 1'b0;
   end

   // Advances the model by one accepted byte and queues the channel values a
   // completed, well-terminated frame produces.
   task automatic take_byte(input logic [7:0] rx);
      logic [8*PayloadBytes-1:0] payload;
      channel_type res;
      if (frame_pos >= PosW'(FrameLen)) frame_pos = '0;
      // While no frame is open, anything but a header is line noise.
      if (frame_pos == '0 && rx != SbusHeader) return;
      if (frame_pos < FooterPos) frame_bytes[frame_pos] = rx;
      frame_pos = frame_pos + 1'b1;
      if (frame_pos != PosW'(FrameLen)) return;
      frame_pos = '0;
      if (rx != footer_setting) begin
         frames_dropped++;
         return;
      end
      // The channels sit back to back, LSB first, in the payload bytes.
      for (int i = 0; i < PayloadBytes; i++) payload[i*8 +: 8] = frame_bytes[FirstChanByte + i];
      for (int k = 0; k < NumChannels; k++) begin
         res.index = ChanIdxW'(k);
         res.value = payload[k*ChanW +: ChanW];
         res.last  = (k == NumChannels - 1);
         channel_queue.push_back(res);
      end
      frames_decoded++;
   endtask

   task automatic queue_byte(input logic [7:0] b);
      byte_queue.push_back(b);
      bytes_queued++;
   endtask

   task automatic queue_frame(input logic [7:0] end_byte, input int fill,
                              input logic [7:0] flags);
      logic [8*PayloadBytes-1:0] payload;
      logic [ChanW-1:0] ch;
      queue_byte(SbusHeader);
      for (int k = 0; k < NumChannels; k++) begin
         case (fill)
            FillZero: ch = '0;
            FillOnes: ch = '1;
            default: begin
               case ($urandom_range(0, 5))
                  0: ch = '0;
                  1: ch = '1;
                  default: ch = ChanW'($urandom_range(0, 2047));
               endcase
            end
         endcase
         payload[k*ChanW +: ChanW] = ch;
      end
      for (int i = 0; i < PayloadBytes; i++) queue_byte(payload[i*8 +: 8]);
      queue_byte(flags);
      queue_byte(end_byte);
   endtask

   // Mostly well-formed frames with random content, mixed with frames that
   // carry a wrong end byte and with bursts of non-header noise while idle.
   task automatic queue_random(input int n_bytes);
      int made, pick, cnt;
      logic [7:0] b;
      made = 0;
      while (made < n_bytes) begin
         pick = $urandom_range(0, 19);
         if (pick < 3) begin
            cnt = $urandom_range(1, 3);
            for (int i = 0; i < cnt; i++) begin
               do b = 8'($urandom_range(0, 255)); while (b == SbusHeader);
               queue_byte(b);
            end
            made += cnt;
         end else begin
            if (pick < 5)
               queue_frame(footer_setting ^ 8'($urandom_range(1, 255)), FillMixed,
                           8'($urandom_range(0, 255)));
            else if (pick == 5)
               queue_frame(footer_setting, FillZero, 8'h00);
            else if (pick == 6)
               queue_frame(footer_setting, FillOnes, 8'hFF);
            else
               queue_frame(footer_setting, FillMixed, 8'($urandom_range(0, 255)));
            made += FrameLen;
         end
      end
   endtask

   // Waits until every byte is taken and every channel request has come back,
   // then gives a dropped frame time to leave the pipeline.
   task automatic settle();
      while (bytes_taken != bytes_queued || channel_queue.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_footer(input logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      footer_setting = value;
      footer_writes++;
   endtask

   // Byte driver: the model is advanced at the edge where a request is taken,
   // then the next byte (or an idle gap) is presented.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         frame_pos = '0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            take_byte(req_tdata);
            bytes_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (byte_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_queue.pop_front();
               if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor with random stall bursts on the receiving side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (channel_queue.size() == 0) begin
               errors++;
               if (errors <= MaxReports)
                  $display("%0t: unexpected channel request: index %0d value %0d last %0d",
                           $time, rsp_tdata[3:0], rsp_tdata[14:4], rsp_tlast);
            end else begin
               want = channel_queue.pop_front();
               channels_checked++;
               if (rsp_tdata[3:0] !== want.index || rsp_tdata[14:4] !== want.value ||
                   rsp_tlast !== want.last) begin
                  errors++;
                  if (errors <= MaxReports)
                     $display("%0t: expected index %0d value %0d last %0d, got index %0d value %0d last %0d",
                              $time, want.index, want.value, want.last,
                              rsp_tdata[3:0], rsp_tdata[14:4], rsp_tlast);
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which no handshake of any kind completes.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      logic [7:0] footer_plan [4];
      footer_plan[0] = 8'hFF;
      footer_plan[1] = 8'($urandom_range(1, 254));
      footer_plan[2] = 8'h00;
      footer_plan[3] = 8'($urandom_range(1, 254));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed start under the reset footer: idle noise bytes 0x00 and 0xF0,
      // then a frame of full-scale channels whose flags byte is a header value
      // inside the frame.
      queue_byte(8'h00);
      queue_byte(8'hF0);
      queue_frame(8'h00, FillOnes, SbusHeader);
      settle();

      for (int p = 0; p < 4; p++) begin
         write_footer(footer_plan[p]);
         calm = (p == 3);
         queue_random(PhaseBytes);
         settle();
      end

      $display("Sent %0d bytes under %0d footer writes: %0d frames decoded, %0d dropped.",
               bytes_taken, footer_writes, frames_decoded, frames_dropped);
      $display("Checked %0d channel values, %0d errors.", channels_checked, errors);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/sbusfd_pkg.sv
hw/rtl/sbusfd_unpacker.sv
hw/rtl/sbus_frame_decoder.sv
hw/rtl/sbusfd_checker.sv
sim/tb_sbus_frame_decoder.sv
